FILE: rtl/cau_pkg.sv
`default_nettype none

package cau_pkg;

    // Width of every operand and result field on the ports.
    localparam int FIELD_W = 32;
    // Width of the wide numerator and denominator fields of a job.
    localparam int NUM_W = 64;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    // Job queue between the front and the back end.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;

    // One classified job. Simple operations carry their finished result;
    // a division carries magnitudes, signs and the squared divisor.
    typedef struct packed {
        logic [1:0]         op;
        logic [FIELD_W-1:0] res_real;
        logic [FIELD_W-1:0] res_imag;
        logic [1:0]         status;
        logic [NUM_W-1:0]   num_real;
        logic [NUM_W-1:0]   num_imag;
        logic [NUM_W-1:0]   den;
        logic               neg_real;
        logic               neg_imag;
    } job_t;

    typedef struct packed {
        logic [QPTR_W:0] count;
        logic            full;
        logic            empty;
    } queue_stat_t;

endpackage

`default_nettype wire

FILE: rtl/complex_arith_unit.sv
// Throughput: one transaction per cycle while s_tready is high and the result port is not
// stalled; all operations share the same pipeline, and the quotient path has one
// restoring-division stage per quotient bit.
// Reset: synchronous, active low; it empties the pipeline, the job queue and the output
// buffer. No clearing pass is needed after reset.
`default_nettype none

module complex_arith_unit #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // a_real, a_imag, b_real, b_imag
    input  wire logic [1:0]   s_tuser,   // operation
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // result_real, result_imag
    output logic [1:0]        m_tuser    // status
);

    logic                  s_accept;
    logic                  job_valid;
    logic                  job_pop;
    logic [1:0]            inflight_cnt;
    cau_pkg::job_t         front_job, head_job;
    cau_pkg::queue_stat_t  q_stat;

    // Accept only while the queue can hold every job still in the front end.
    assign s_tready = (5'(q_stat.count) + 5'(inflight_cnt)) < 5'(cau_pkg::QUEUE_DEPTH);
    assign s_accept = s_tvalid && s_tready;

    cau_front #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_accept),
        .in_op        (s_tuser),
        .in_data      (s_tdata),
        .job          (front_job),
        .job_valid    (job_valid),
        .inflight_cnt (inflight_cnt)
    );

    cau_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_valid),
        .push_job (front_job),
        .pop      (job_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    cau_back #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!q_stat.empty),
        .job       (head_job),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // The credit check must keep the queue from overflowing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> !q_stat.full)
        else $error("job queue overflow");

    // A divide-by-zero result carries zero parts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == cau_pkg::ST_DIV0) |-> (m_tdata == 64'd0))
        else $error("divide-by-zero result is not zero");

    // The back end holds a waiting job only when the output buffer is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_stat.empty && !job_pop) |-> m_tvalid)
        else $error("back end stalled without pending results");

endmodule

`default_nettype wire

FILE: rtl/cau_front.sv
`default_nettype none

module cau_front #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic [1:0]    in_op,
    input  wire logic [127:0]  in_data,
    output cau_pkg::job_t      job,
    output logic               job_valid,
    output logic [1:0]         inflight_cnt
);

    localparam int OPW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int PW  = 2 * OPW;
    localparam int SW  = PW + 1;
    localparam logic signed [SW-1:0] SMAX = {{(SW-OPW+1){1'b0}}, {(OPW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-OPW+1){1'b1}}, {(OPW-1){1'b0}}};

    // Saturate a wide value to the operand range; the top bit flags clipping.
    function automatic logic [OPW:0] sat_f(input logic signed [SW-1:0] x);
        logic [OPW:0] r;
        if (x > SMAX) begin
            r = {1'b1, SMAX[OPW-1:0]};
        end else if (x < SMIN) begin
            r = {1'b1, SMIN[OPW-1:0]};
        end else begin
            r = {1'b0, x[OPW-1:0]};
        end
        return r;
    endfunction

    logic                  v1_reg, v2_reg, v3_reg;
    logic [1:0]            op1_reg, op2_reg;
    logic signed [OPW-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [PW-1:0]  prr_reg, pii_reg, pri_reg, pir_reg, qrr_reg, qii_reg;
    logic signed [OPW:0]   sre_reg, sim_reg;
    cau_pkg::job_t         job_reg, job_next;

    logic signed [SW-1:0]  mre, mim, nre, nim;
    logic [PW-1:0]         den, mag_re, mag_im;
    logic [OPW:0]          sat_re, sat_im;

    // Valid bits of the three front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Operand capture: low operand bits are kept as signed values.
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            op1_reg <= in_op;
            ar1_reg <= in_data[OPW-1:0];
            ai1_reg <= in_data[32 +: OPW];
            br1_reg <= in_data[64 +: OPW];
            bi1_reg <= in_data[96 +: OPW];
        end
    end

    // Products and the plain sums or differences.
    always_ff @(posedge aclk) begin
        op2_reg <= op1_reg;
        prr_reg <= ar1_reg * br1_reg;
        pii_reg <= ai1_reg * bi1_reg;
        pri_reg <= ar1_reg * bi1_reg;
        pir_reg <= ai1_reg * br1_reg;
        qrr_reg <= br1_reg * br1_reg;
        qii_reg <= bi1_reg * bi1_reg;
        if (op1_reg == cau_pkg::OP_SUB) begin
            sre_reg <= (OPW+1)'(ar1_reg) - (OPW+1)'(br1_reg);
            sim_reg <= (OPW+1)'(ai1_reg) - (OPW+1)'(bi1_reg);
        end else begin
            sre_reg <= (OPW+1)'(ar1_reg) + (OPW+1)'(br1_reg);
            sim_reg <= (OPW+1)'(ai1_reg) + (OPW+1)'(bi1_reg);
        end
    end

    // Classify the item and finish everything except the division.
    always_comb begin
        mre    = SW'(prr_reg) - SW'(pii_reg);
        mim    = SW'(pri_reg) + SW'(pir_reg);
        nre    = SW'(prr_reg) + SW'(pii_reg);
        nim    = SW'(pir_reg) - SW'(pri_reg);
        den    = $unsigned(qrr_reg) + $unsigned(qii_reg);
        mag_re = nre[SW-1] ? PW'(-nre) : nre[PW-1:0];
        mag_im = nim[SW-1] ? PW'(-nim) : nim[PW-1:0];
        sat_re = '0;
        sat_im = '0;
        job_next          = '0;
        job_next.op       = op2_reg;
        job_next.num_real = cau_pkg::NUM_W'(mag_re);
        job_next.num_imag = cau_pkg::NUM_W'(mag_im);
        job_next.den      = cau_pkg::NUM_W'(den);
        job_next.neg_real = nre[SW-1];
        job_next.neg_imag = nim[SW-1];
        unique case (op2_reg)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                sat_re = sat_f(SW'(sre_reg));
                sat_im = sat_f(SW'(sim_reg));
            end
            cau_pkg::OP_MUL: begin
                sat_re = sat_f(mre >>> FRAC_BITS);
                sat_im = sat_f(mim >>> FRAC_BITS);
            end
            cau_pkg::OP_DIV: begin
                sat_re = '0;
                sat_im = '0;
            end
        endcase
        job_next.res_real = cau_pkg::FIELD_W'(signed'(sat_re[OPW-1:0]));
        job_next.res_imag = cau_pkg::FIELD_W'(signed'(sat_im[OPW-1:0]));
        if (op2_reg == cau_pkg::OP_DIV) begin
            job_next.status = (den == '0) ? cau_pkg::ST_DIV0 : cau_pkg::ST_OK;
        end else begin
            job_next.status = (sat_re[OPW] || sat_im[OPW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

    assign job          = job_reg;
    assign job_valid    = v3_reg;
    assign inflight_cnt = 2'(v1_reg) + 2'(v2_reg) + 2'(v3_reg);

endmodule

`default_nettype wire

FILE: rtl/cau_queue.sv
`default_nettype none

module cau_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire cau_pkg::job_t  push_job,
    input  wire logic           pop,
    output cau_pkg::job_t       head_job,
    output cau_pkg::queue_stat_t stat
);

    cau_pkg::job_t                mem_reg [cau_pkg::QUEUE_DEPTH];
    logic [cau_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [cau_pkg::QPTR_W:0]     count_reg, count_next;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head_job   = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == (cau_pkg::QPTR_W+1)'(cau_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/cau_back.sv
`default_nettype none

module cau_back #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         job_valid,
    input  wire cau_pkg::job_t job,
    output logic              job_pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,
    output logic [1:0]        m_tuser
);

    localparam int OPW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int PW  = 2 * OPW;
    localparam int QB  = OPW + 1;
    localparam int NW  = PW + FRAC_BITS;
    localparam int HW  = NW - QB;
    localparam int CW  = (HW > PW) ? HW : PW;
    localparam logic [QB-1:0]  QVMAX = {2'b00, {(OPW-1){1'b1}}};
    localparam logic [QB-1:0]  QVMIN = {2'b01, {(OPW-1){1'b0}}};
    localparam logic [OPW-1:0] VMAX  = {1'b0, {(OPW-1){1'b1}}};
    localparam logic [OPW-1:0] VMIN  = {1'b1, {(OPW-1){1'b0}}};

    logic                en;
    logic [QB:0]         v_reg;
    cau_pkg::job_t       jb_reg  [QB+1];
    logic [PW-1:0]       rre_reg [QB+1];
    logic [PW-1:0]       rim_reg [QB+1];
    logic [QB-1:0]       qre_reg [QB+1];
    logic [QB-1:0]       qim_reg [QB+1];
    logic [QB-1:0]       lre_reg [QB+1];
    logic [QB-1:0]       lim_reg [QB+1];
    logic                ore_reg [QB+1];
    logic                oim_reg [QB+1];

    logic [NW-1:0]       nfr, nfi;
    logic [HW-1:0]       r0r, r0i;
    logic [CW-1:0]       r0rc, r0ic, denc;

    logic [1:0]          ocnt_reg;
    logic [65:0]         ob0_reg, ob1_reg, ob_new;
    logic                ob_push, ob_pop;
    logic [OPW-1:0]      qr_val, qi_val;
    logic                qr_flag, qi_flag;
    logic [QB-1:0]       qr_neg, qi_neg;
    logic [cau_pkg::FIELD_W-1:0] fin_re, fin_im;
    logic [1:0]          fin_st;

    // The whole back end advances while the output buffer has room.
    assign en      = (ocnt_reg != 2'd2);
    assign job_pop = en && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QB-1:0], job_pop};
        end
    end

    // Divider setup: scale the numerators and check for a quotient
    // too large to represent, which then saturates.
    always_comb begin
        nfr  = NW'(job.num_real[PW-1:0]) << FRAC_BITS;
        nfi  = NW'(job.num_imag[PW-1:0]) << FRAC_BITS;
        r0r  = nfr[NW-1:QB];
        r0i  = nfi[NW-1:QB];
        r0rc = CW'(r0r);
        r0ic = CW'(r0i);
        denc = CW'(job.den[PW-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            jb_reg[0]  <= job;
            rre_reg[0] <= r0rc[PW-1:0];
            rim_reg[0] <= r0ic[PW-1:0];
            qre_reg[0] <= '0;
            qim_reg[0] <= '0;
            lre_reg[0] <= nfr[QB-1:0];
            lim_reg[0] <= nfi[QB-1:0];
            ore_reg[0] <= (r0rc >= denc);
            oim_reg[0] <= (r0ic >= denc);
        end
    end

    // One restoring division step per stage, one quotient bit each.
    for (genvar s = 1; s <= QB; s++) begin : g_stage
        logic [PW:0] dd, t_re, t_im, df_re, df_im;

        always_comb begin
            dd    = {1'b0, jb_reg[s-1].den[PW-1:0]};
            t_re  = {rre_reg[s-1], lre_reg[s-1][QB-s]};
            t_im  = {rim_reg[s-1], lim_reg[s-1][QB-s]};
            df_re = t_re - dd;
            df_im = t_im - dd;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                jb_reg[s]  <= jb_reg[s-1];
                lre_reg[s] <= lre_reg[s-1];
                lim_reg[s] <= lim_reg[s-1];
                ore_reg[s] <= ore_reg[s-1];
                oim_reg[s] <= oim_reg[s-1];
                if (t_re >= dd) begin
                    rre_reg[s] <= df_re[PW-1:0];
                    qre_reg[s] <= {qre_reg[s-1][QB-2:0], 1'b1};
                end else begin
                    rre_reg[s] <= t_re[PW-1:0];
                    qre_reg[s] <= {qre_reg[s-1][QB-2:0], 1'b0};
                end
                if (t_im >= dd) begin
                    rim_reg[s] <= df_im[PW-1:0];
                    qim_reg[s] <= {qim_reg[s-1][QB-2:0], 1'b1};
                end else begin
                    rim_reg[s] <= t_im[PW-1:0];
                    qim_reg[s] <= {qim_reg[s-1][QB-2:0], 1'b0};
                end
            end
        end
    end

    // Apply the sign to each quotient and saturate.
    always_comb begin
        qr_neg = -qre_reg[QB];
        qi_neg = -qim_reg[QB];
        if (jb_reg[QB].neg_real) begin
            qr_flag = ore_reg[QB] || (qre_reg[QB] > QVMIN);
            qr_val  = qr_flag ? VMIN : qr_neg[OPW-1:0];
        end else begin
            qr_flag = ore_reg[QB] || (qre_reg[QB] > QVMAX);
            qr_val  = qr_flag ? VMAX : qre_reg[QB][OPW-1:0];
        end
        if (jb_reg[QB].neg_imag) begin
            qi_flag = oim_reg[QB] || (qim_reg[QB] > QVMIN);
            qi_val  = qi_flag ? VMIN : qi_neg[OPW-1:0];
        end else begin
            qi_flag = oim_reg[QB] || (qim_reg[QB] > QVMAX);
            qi_val  = qi_flag ? VMAX : qim_reg[QB][OPW-1:0];
        end
        fin_re = jb_reg[QB].res_real;
        fin_im = jb_reg[QB].res_imag;
        fin_st = jb_reg[QB].status;
        if (jb_reg[QB].op == cau_pkg::OP_DIV && jb_reg[QB].status != cau_pkg::ST_DIV0) begin
            fin_re = cau_pkg::FIELD_W'(signed'(qr_val));
            fin_im = cau_pkg::FIELD_W'(signed'(qi_val));
            fin_st = (qr_flag || qi_flag) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
        ob_new = {fin_st, fin_im, fin_re};
    end

    // Two-entry output buffer; the head entry drives the result port.
    assign ob_push = en && v_reg[QB];
    assign ob_pop  = (ocnt_reg != 2'd0) && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= 2'd0;
        end else begin
            ocnt_reg <= ocnt_reg + 2'(ob_push) - 2'(ob_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (ob_pop) begin
            if (ocnt_reg == 2'd2) begin
                ob0_reg <= ob1_reg;
            end else begin
                ob0_reg <= ob_new;
            end
        end else if (ocnt_reg == 2'd0) begin
            ob0_reg <= ob_new;
        end
        if (ocnt_reg == 2'd1 && !ob_pop) begin
            ob1_reg <= ob_new;
        end
    end

    assign m_tvalid = (ocnt_reg != 2'd0);
    assign m_tdata  = ob0_reg[63:0];
    assign m_tuser  = ob0_reg[65:64];

endmodule

`default_nettype wire

FILE: verif/complex_arith_unit_tb.sv
`default_nettype none

module complex_arith_unit_tb;

    localparam int FRAC = 16;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] res_real;
        logic [31:0] res_imag;
        logic [1:0]  status;
    } cplx_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    cplx_result_t expected_results[$];
    int           mismatch_count;
    int           extra_count;
    longint       cycle_count;
    bit           sink_stall_en;

    complex_arith_unit #(.FRAC_BITS(16), .DATA_WIDTH(32)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Floor shift of a 128-bit signed value.
    function automatic logic signed [127:0] floor_shift(logic signed [127:0] x);
        return x >>> FRAC;
    endfunction

    function automatic longint clamp_part(logic signed [127:0] v, inout bit sat_flag);
        if (v > VMAX) begin
            sat_flag = 1'b1;
            return VMAX;
        end
        if (v < VMIN) begin
            sat_flag = 1'b1;
            return VMIN;
        end
        return longint'(v);
    endfunction

    // Quotient of (n << FRAC) / d truncated toward zero; the magnitude is capped
    // at 2^32 so that a huge value still saturates.
    function automatic longint div_part(logic signed [127:0] n, logic signed [127:0] d,
                                        inout bit sat_flag);
        logic [127:0] mag;
        logic [127:0] q;
        logic signed [127:0] sq;
        mag = (n < 0) ? -n : n;
        q = (mag << FRAC) / d;
        if (q > (128'd1 << 32)) q = 128'd1 << 32;
        sq = (n < 0) ? -$signed(q) : $signed(q);
        return clamp_part(sq, sat_flag);
    endfunction

    // Computes the expected complex result for one operand set.
    function automatic cplx_result_t complex_result(logic [1:0] op, logic signed [31:0] ar,
                                                    logic signed [31:0] ai,
                                                    logic signed [31:0] br,
                                                    logic signed [31:0] bi);
        cplx_result_t r;
        bit sat_flag;
        logic signed [127:0] wr, wi, den;
        longint pr, pi;
        sat_flag = 1'b0;
        pr = 0;
        pi = 0;
        r.status = cau_pkg::ST_OK;
        case (op)
            cau_pkg::OP_ADD: begin
                wr = 128'(ar) + 128'(br);
                wi = 128'(ai) + 128'(bi);
            end
            cau_pkg::OP_SUB: begin
                wr = 128'(ar) - 128'(br);
                wi = 128'(ai) - 128'(bi);
            end
            cau_pkg::OP_MUL: begin
                wr = floor_shift(128'(ar) * 128'(br) - 128'(ai) * 128'(bi));
                wi = floor_shift(128'(ar) * 128'(bi) + 128'(ai) * 128'(br));
            end
            default: begin
                wr = 128'(ar) * 128'(br) + 128'(ai) * 128'(bi);
                wi = 128'(ai) * 128'(br) - 128'(ar) * 128'(bi);
            end
        endcase
        if (op == cau_pkg::OP_DIV) begin
            den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
            if (den == 0) begin
                r.status = cau_pkg::ST_DIV0;
            end else begin
                pr = div_part(wr, den, sat_flag);
                pi = div_part(wi, den, sat_flag);
            end
        end else begin
            pr = clamp_part(wr, sat_flag);
            pi = clamp_part(wi, sat_flag);
        end
        if (r.status == cau_pkg::ST_OK && sat_flag) r.status = cau_pkg::ST_SAT;
        r.res_real = pr[31:0];
        r.res_imag = pi[31:0];
        return r;
    endfunction

    // Sends one transaction after a random gap and records its expected result.
    task automatic send_operands(logic [1:0] op, logic [31:0] ar, logic [31:0] ai,
                                 logic [31:0] br, logic [31:0] bi);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bi, br, ai, ar};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(complex_result(op, ar, ai, br, bi));
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        cplx_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                extra_count++;
                if (mismatch_count + extra_count <= 10)
                    $display("unexpected result %h status %0d", m_tdata, m_tuser);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.res_real || m_tdata[63:32] !== want.res_imag ||
                    m_tuser !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp re %h im %h st %0d, got re %h im %h st %0d",
                                 want.res_real, want.res_imag, want.status,
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                end
            end
        end
    end

    // Receiver stall: per result a random wait, with stall-free stretches.
    initial begin
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            wait_cycles = sink_stall_en ? $urandom_range(0, 15) : 0;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    function automatic logic [31:0] edge_value(int k);
        case (k % 8)
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            5: return 32'hFFFF_0000;
            6: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Directed extremes, every operation and the zero divisor.
    task automatic test_directed();
        logic [1:0] op;
        for (int i = 0; i < 4; i++) begin
            op = 2'(i);
            send_operands(op, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
            send_operands(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send_operands(op, 32'h0003_0000, 32'hFFFE_8000, 32'h0001_0000, 32'h0002_0000);
            send_operands(op, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        end
        send_operands(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        send_operands(cau_pkg::OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
        send_operands(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
        send_operands(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_operands(cau_pkg::OP_MUL, 32'h0000_8000, 32'h0000_0001, 32'hFFFF_FFFF,
                      32'h0000_0003);
        end_burst();
    endtask

    // Random operands: full-range, small-magnitude and edge values mixed.
    task automatic test_random(int count);
        logic [31:0] v[4];
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(0, 3))
                    0: v[k] = $urandom;
                    1: v[k] = 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
                    2: v[k] = edge_value($urandom_range(0, 7));
                    default: v[k] = 32'($signed($urandom_range(0, 32'h03FF_FFFF))
                                        - 32'sh0200_0000);
                endcase
            end
            send_operands(2'($urandom_range(0, 3)), v[0], v[1], v[2], v[3]);
        end
        end_burst();
    endtask

    // Back-to-back traffic with the receiver always ready.
    task automatic test_full_rate(int count);
        sink_stall_en = 1'b0;
        for (int n = 0; n < count; n++) begin
            s_tvalid <= 1'b1;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
            s_tuser  <= 2'($urandom_range(0, 3));
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            expected_results.push_back(complex_result(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                                      s_tdata[95:64], s_tdata[127:96]));
        end
        end_burst();
        sink_stall_en = 1'b1;
    endtask

    initial begin
        int drain;
        mismatch_count = 0;
        extra_count = 0;
        cycle_count = 0;
        sink_stall_en = 1'b1;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = cau_pkg::OP_ADD;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(700);
        test_full_rate(150);
        test_random(80);
        // Drain outstanding results, then allow for the pipeline latency.
        drain = 0;
        while (expected_results.size() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (60) @(posedge aclk);
        if (expected_results.size() == 0 && mismatch_count == 0 && extra_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
